// ===== rtl/core/hhpf_pkg.sv =====
package hhpf_pkg;

    localparam int unsigned PATTERN_MAX_BYTES = 32;
    localparam int unsigned OFFSET_W          = 17;
    localparam int unsigned CFG_INDEX_W       = 3;
    localparam int unsigned CFG_DATA_W        = 64;
    localparam int unsigned PLEN_W            = 6;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'h06;

    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_H  = 8'h48;
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [2:0] HOST_KEY_LEN = 3'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_0_7   = 3'd0,
        CFG_PATTERN_8_15  = 3'd1,
        CFG_PATTERN_16_23 = 3'd2,
        CFG_PATTERN_24_31 = 3'd3,
        CFG_PATTERN_LEN   = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SEARCH,
        PH_TOKEN,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        VERDICT_NOT_IPV4  = 3'd0,
        VERDICT_NOT_TCP   = 3'd1,
        VERDICT_NO_PAYLD  = 3'd2,
        VERDICT_NOT_GET   = 3'd3,
        VERDICT_NO_HOST   = 3'd4,
        VERDICT_MISMATCH  = 3'd5,
        VERDICT_MATCH     = 3'd6
    } t_verdict;

    // header lengths below the minimum are taken as 20 bytes
    function automatic logic [5:0] at_least_20(input logic [5:0] v);
        return (v < 6'd20) ? 6'd20 : v;
    endfunction

    // "Host: " one character at a time
    function automatic logic [7:0] host_key_byte(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h6f;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h3a;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/http_host_prefix_filter.sv =====
// Ethernet/IPv4/TCP frame filter: bytes of one frame enter on the slave stream, one per
// cycle, with tlast on the final byte. The first payload byte must be 'G'; the payload is
// then searched for the first "Host: " and the host token that follows (up to CR, LF or
// the end of the IP datagram) is compared against the first pattern_length bytes of the
// configured pattern. A single result transaction (verdict and block flag) leaves on the
// master stream for every frame, once its last byte has passed the input register and the
// result register. The block takes one byte per cycle; the per-byte parse stage between
// the input and result registers updates all frame state in that cycle; it stalls only
// while a finished result waits and the next frame's last byte needs the result register.
module http_host_prefix_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte[7:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // verdict[2:0], block[3], zeros[7:4]
);

    // configuration
    logic [63:0]                     r_pat_word [4];
    logic [hhpf_pkg::PLEN_W-1:0]     r_plen;

    // input register
    logic                            r_in_valid;
    logic [7:0]                      r_in_byte;
    logic                            r_in_last;

    // frame state
    logic [hhpf_pkg::OFFSET_W-1:0]   r_offset, n_offset;
    logic [15:0]                     r_ether, n_ether;
    logic [5:0]                      r_ihl, n_ihl;
    logic [15:0]                     r_total, n_total;
    logic [7:0]                      r_proto, n_proto;
    logic [5:0]                      r_thl, n_thl;
    logic [2:0]                      r_kp, n_kp;
    logic [5:0]                      r_ci, n_ci;
    hhpf_pkg::t_phase                r_phase, n_phase;
    hhpf_pkg::t_verdict              r_pending, n_pending;

    // result register
    logic                            r_out_valid;
    hhpf_pkg::t_verdict              r_verdict;

    logic                            w_advance;
    logic                            w_in_accept;
    logic [hhpf_pkg::PLEN_W-1:0]     w_plen_eff;
    logic [7:0]                      w_pat_byte;
    hhpf_pkg::t_verdict              w_result;
    logic [hhpf_pkg::OFFSET_W-1:0]   w_payload_start;
    logic [hhpf_pkg::OFFSET_W-1:0]   w_payload_end;
    logic [hhpf_pkg::OFFSET_W-1:0]   w_tcp_offset;

    function automatic hhpf_pkg::t_verdict header_verdict(
        input logic [15:0] ether,
        input logic [7:0]  proto,
        input logic [15:0] total,
        input logic [5:0]  ihl,
        input logic [5:0]  thl,
        input logic [7:0]  first
    );
        logic [6:0] hdr_sum;
        hhpf_pkg::t_verdict v;
        hdr_sum = {1'b0, hhpf_pkg::at_least_20(ihl)} + {1'b0, hhpf_pkg::at_least_20(thl)};
        if (ether != hhpf_pkg::ETHERTYPE_IPV4) begin
            v = hhpf_pkg::VERDICT_NOT_IPV4;
        end else if (proto != hhpf_pkg::IP_PROTO_TCP) begin
            v = hhpf_pkg::VERDICT_NOT_TCP;
        end else if (total <= {9'b0, hdr_sum}) begin
            v = hhpf_pkg::VERDICT_NO_PAYLD;
        end else if (first != hhpf_pkg::CHAR_G) begin
            v = hhpf_pkg::VERDICT_NOT_GET;
        end else begin
            v = hhpf_pkg::VERDICT_NO_HOST;
        end
        return v;
    endfunction

    // an item without a result never needs the result register
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, (r_verdict == hhpf_pkg::VERDICT_MATCH), r_verdict};

    assign w_plen_eff = (r_plen > hhpf_pkg::PLEN_W'(hhpf_pkg::PATTERN_MAX_BYTES))
                      ? hhpf_pkg::PLEN_W'(hhpf_pkg::PATTERN_MAX_BYTES) : r_plen;
    assign w_pat_byte = r_pat_word[r_ci[4:3]][{r_ci[2:0], 3'b000} +: 8];

    assign w_tcp_offset    = {11'b0, r_ihl} + 17'd26;
    assign w_payload_start = {11'b0, r_ihl} + {11'b0, r_thl} + 17'd14;
    assign w_payload_end   = {1'b0, r_total} + 17'd14;

    always_comb begin
        n_offset  = (r_offset == hhpf_pkg::OFFSET_MAX) ? r_offset : r_offset + 1'b1;
        n_ether   = r_ether;
        n_ihl     = r_ihl;
        n_total   = r_total;
        n_proto   = r_proto;
        n_thl     = r_thl;
        n_kp      = r_kp;
        n_ci      = r_ci;
        n_phase   = r_phase;
        n_pending = r_pending;
        w_result  = r_pending;

        unique case (r_phase)
            hhpf_pkg::PH_HEADER: begin
                case (r_offset)
                    17'd12:  n_ether[15:8] = r_in_byte;
                    17'd13:  n_ether[7:0]  = r_in_byte;
                    17'd14:  n_ihl   = hhpf_pkg::at_least_20({r_in_byte[3:0], 2'b00});
                    17'd16:  n_total[15:8] = r_in_byte;
                    17'd17:  n_total[7:0]  = r_in_byte;
                    17'd23:  n_proto = r_in_byte;
                    default: ;
                endcase
                if (r_ihl != 6'd0 && r_offset == w_tcp_offset) begin
                    n_thl = hhpf_pkg::at_least_20({r_in_byte[7:4], 2'b00});
                end
                // first payload byte: decide from the headers whether to search
                if (r_ihl != 6'd0 && r_thl != 6'd0 && r_offset == w_payload_start) begin
                    n_pending = header_verdict(r_ether, r_proto, r_total, r_ihl, r_thl,
                                               r_in_byte);
                    n_phase   = (n_pending == hhpf_pkg::VERDICT_NO_HOST)
                              ? hhpf_pkg::PH_SEARCH : hhpf_pkg::PH_DONE;
                end
            end
            hhpf_pkg::PH_SEARCH: begin
                if (r_offset >= w_payload_end) begin
                    n_phase = hhpf_pkg::PH_DONE;
                end else begin
                    if (r_kp < hhpf_pkg::HOST_KEY_LEN &&
                        r_in_byte == hhpf_pkg::host_key_byte(r_kp)) begin
                        n_kp = r_kp + 1'b1;
                    end else begin
                        n_kp = (r_in_byte == hhpf_pkg::CHAR_H) ? 3'd1 : 3'd0;
                    end
                    if (n_kp >= hhpf_pkg::HOST_KEY_LEN) begin
                        n_ci = 6'd0;
                        if (w_plen_eff == '0) begin
                            n_pending = hhpf_pkg::VERDICT_MATCH;
                            n_phase   = hhpf_pkg::PH_DONE;
                        end else begin
                            n_pending = hhpf_pkg::VERDICT_MISMATCH;
                            n_phase   = hhpf_pkg::PH_TOKEN;
                        end
                    end
                end
            end
            hhpf_pkg::PH_TOKEN: begin
                if (r_offset >= w_payload_end) begin
                    n_phase = hhpf_pkg::PH_DONE;
                end else if (r_in_byte == hhpf_pkg::CHAR_CR ||
                             r_in_byte == hhpf_pkg::CHAR_LF) begin
                    n_phase = hhpf_pkg::PH_DONE;
                end else if (r_ci >= w_plen_eff) begin
                    n_pending = hhpf_pkg::VERDICT_MATCH;
                    n_phase   = hhpf_pkg::PH_DONE;
                end else if (r_in_byte != w_pat_byte) begin
                    n_pending = hhpf_pkg::VERDICT_MISMATCH;
                    n_phase   = hhpf_pkg::PH_DONE;
                end else begin
                    n_ci = r_ci + 1'b1;
                    if (n_ci >= w_plen_eff) begin
                        n_pending = hhpf_pkg::VERDICT_MATCH;
                        n_phase   = hhpf_pkg::PH_DONE;
                    end
                end
            end
            hhpf_pkg::PH_DONE: ;
            default: ;
        endcase

        // frame ended before its payload: judge from what has arrived
        if (n_phase == hhpf_pkg::PH_HEADER) begin
            w_result = header_verdict(n_ether, n_proto, n_total, n_ihl, n_thl, 8'h00);
        end else begin
            w_result = n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_pat_word[i] <= '0;
            end
            r_plen <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hhpf_pkg::CFG_PATTERN_0_7:   r_pat_word[0] <= i_cfg_data;
                hhpf_pkg::CFG_PATTERN_8_15:  r_pat_word[1] <= i_cfg_data;
                hhpf_pkg::CFG_PATTERN_16_23: r_pat_word[2] <= i_cfg_data;
                hhpf_pkg::CFG_PATTERN_24_31: r_pat_word[3] <= i_cfg_data;
                hhpf_pkg::CFG_PATTERN_LEN:   r_plen <= i_cfg_data[hhpf_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_ether   <= '0;
            r_ihl     <= '0;
            r_total   <= '0;
            r_proto   <= '0;
            r_thl     <= '0;
            r_kp      <= '0;
            r_ci      <= '0;
            r_phase   <= hhpf_pkg::PH_HEADER;
            r_pending <= hhpf_pkg::VERDICT_NOT_IPV4;
        end else if (w_advance) begin
            if (r_in_last) begin
                r_offset  <= '0;
                r_ether   <= '0;
                r_ihl     <= '0;
                r_total   <= '0;
                r_proto   <= '0;
                r_thl     <= '0;
                r_kp      <= '0;
                r_ci      <= '0;
                r_phase   <= hhpf_pkg::PH_HEADER;
                r_pending <= hhpf_pkg::VERDICT_NOT_IPV4;
            end else begin
                r_offset  <= n_offset;
                r_ether   <= n_ether;
                r_ihl     <= n_ihl;
                r_total   <= n_total;
                r_proto   <= n_proto;
                r_thl     <= n_thl;
                r_kp      <= n_kp;
                r_ci      <= n_ci;
                r_phase   <= n_phase;
                r_pending <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_verdict <= w_result;
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> m_axis_tvalid)
        else $error("last byte processed without a result transaction");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> (r_phase == hhpf_pkg::PH_HEADER && r_offset == '0))
        else $error("frame state not cleared after last byte");

    a_headers_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != hhpf_pkg::PH_HEADER) |-> (r_ihl != 6'd0 && r_thl != 6'd0))
        else $error("left header phase without both header lengths");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending result");

endmodule
